// ===== design/circle_from_three_points_macros.svh =====
// Assertion macros for the circle_from_three_points block.
// Included by the files that carry concurrent assertions; depends on i_clk and i_rst_n.
`ifndef CIRCLE_FROM_THREE_POINTS_MACROS_SVH
`define CIRCLE_FROM_THREE_POINTS_MACROS_SVH
`ifndef NO_ASSERTIONS
// checked only outside reset
`define CF3P_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define CF3P_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define CF3P_ASSERT(lbl, prop, msg)
`define CF3P_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ===== design/cf3p_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the circumcircle block.
// No dependencies.
package cf3p_pkg;

    // default coordinate width (Q7.16)
    localparam int COORD_WIDTH = 24;

    // collinear threshold register
    localparam int THR_WIDTH = 40;
    localparam logic [THR_WIDTH-1:0] THR_RESET = THR_WIDTH'(1);

    // result status codes
    typedef enum logic [1:0] {
        ST_CIRCLE    = 2'd0,
        ST_COLLINEAR = 2'd1,
        ST_SATURATED = 2'd2
    } t_status;

endpackage

// ===== design/circle_from_three_points.sv =====
`timescale 1ns / 1ps
// Circumcircle of three points: fully pipelined, one triple per clock unless the output stalls.
// Depends on cf3p_pkg and circle_from_three_points_macros.svh.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries the three points, one
//   beat per triple. Output channel (o_out_valid / i_out_stall) carries the
//   centre, radius and status, one beat per input beat, in order.
//   Config channel (i_cfg_valid / o_cfg_ready) writes the collinear
//   threshold; ready is always high, write it only while the block is idle.
// Throughput: one beat per cycle while the output is not stalled. The
//   pipeline is built from the bit-per-stage quotient pipelines
//   (COORD_WIDTH+1 stages, both axes side by side) and the bit-per-stage
//   square root (COORD_WIDTH stages).
// Reset: synchronous, active low; clears all stage valid bits and sets the
//   threshold to 1. No clearing pass is needed.
// Stall: the whole pipeline holds while a finished beat waits on
//   i_out_stall; o_in_stall follows it in the same cycle. Empty stages
//   hold as well, so no beat is lost or repeated.
`include "circle_from_three_points_macros.svh"
module circle_from_three_points #(
    parameter int COORD_WIDTH = cf3p_pkg::COORD_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [cf3p_pkg::THR_WIDTH-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [COORD_WIDTH-1:0]       i_first_x,
    input  logic signed [COORD_WIDTH-1:0]       i_first_y,
    input  logic signed [COORD_WIDTH-1:0]       i_second_x,
    input  logic signed [COORD_WIDTH-1:0]       i_second_y,
    input  logic signed [COORD_WIDTH-1:0]       i_third_x,
    input  logic signed [COORD_WIDTH-1:0]       i_third_y,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [COORD_WIDTH-1:0]       o_center_x,
    output logic signed [COORD_WIDTH-1:0]       o_center_y,
    output logic [COORD_WIDTH-2:0]              o_radius,
    output logic [1:0]                          o_status
);
    import cf3p_pkg::*;

    localparam int W    = COORD_WIDTH;
    localparam int DW   = W + 1;          // coordinate difference
    localparam int PW   = 2 * DW;         // product of two differences
    localparam int DETW = PW + 1;         // determinant
    localparam int LW   = PW;             // squared length (unsigned)
    localparam int LLO  = DW;             // low split of squared length
    localparam int LHI  = LW - LLO;
    localparam int PPW  = 2 * DW + 1;     // partial product
    localparam int TW   = 3 * DW + 1;     // full numerator product
    localparam int NXW  = TW + 1;         // numerator
    localparam int CW   = NXW + 2;        // divider working width
    localparam int QB   = W + 1;          // quotient bits before overflow
    localparam int XW   = 2 * W + 1;      // square root working width
    localparam int RB   = W;              // root bits
    localparam int CMPW = (DETW > THR_WIDTH) ? DETW : THR_WIDTH;
    localparam int NS   = 13 + QB + RB;   // valid stages

    localparam logic [W-2:0]          RMAX   = '1;
    localparam logic signed [W-1:0]   CMAX   = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0]   CMIN   = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W+2:0]   CMAX_E = {4'b0000, {(W-1){1'b1}}};
    localparam logic signed [W+2:0]   CMIN_E = {4'b1111, {(W-1){1'b0}}};

    logic            w_adv;
    logic [NS-1:0]   r_vld;
    logic [THR_WIDTH-1:0] r_thr;

    // ---------------- control ----------------
    assign w_adv       = !(r_vld[NS-1] && i_out_stall);
    assign o_in_stall  = !w_adv;
    assign o_out_valid = r_vld[NS-1];
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NS-2:0], i_in_valid};
        end
    end

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_data;
        end
    end

    // ---------------- stage 1: offsets from first point ----------------
    logic signed [DW-1:0] r1_bx, r1_by, r1_cx, r1_cy;
    logic signed [W-1:0]  r1_x1, r1_y1;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_bx <= $signed({i_second_x[W-1], i_second_x}) - $signed({i_first_x[W-1], i_first_x});
            r1_by <= $signed({i_second_y[W-1], i_second_y}) - $signed({i_first_y[W-1], i_first_y});
            r1_cx <= $signed({i_third_x[W-1], i_third_x}) - $signed({i_first_x[W-1], i_first_x});
            r1_cy <= $signed({i_third_y[W-1], i_third_y}) - $signed({i_first_y[W-1], i_first_y});
            r1_x1 <= i_first_x;
            r1_y1 <= i_first_y;
        end
    end

    // ---------------- stage 2: cross and square products ----------------
    logic signed [PW-1:0] r2_pbc, r2_pbyc, r2_bxx, r2_byy, r2_cxx, r2_cyy;
    logic signed [DW-1:0] r2_bx, r2_by, r2_cx, r2_cy;
    logic signed [W-1:0]  r2_x1, r2_y1;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_pbc  <= r1_bx * r1_cy;
            r2_pbyc <= r1_by * r1_cx;
            r2_bxx  <= r1_bx * r1_bx;
            r2_byy  <= r1_by * r1_by;
            r2_cxx  <= r1_cx * r1_cx;
            r2_cyy  <= r1_cy * r1_cy;
            r2_bx   <= r1_bx;
            r2_by   <= r1_by;
            r2_cx   <= r1_cx;
            r2_cy   <= r1_cy;
            r2_x1   <= r1_x1;
            r2_y1   <= r1_y1;
        end
    end

    // ---------------- stage 3: determinant and squared lengths ----------------
    logic signed [DETW-1:0] r3_det;
    logic [LW-1:0]          r3_lb, r3_lc;
    logic signed [DW-1:0]   r3_bx, r3_by, r3_cx, r3_cy;
    logic signed [W-1:0]    r3_x1, r3_y1;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_det <= DETW'(r2_pbc) - DETW'(r2_pbyc);
            r3_lb  <= $unsigned(r2_bxx) + $unsigned(r2_byy);
            r3_lc  <= $unsigned(r2_cxx) + $unsigned(r2_cyy);
            r3_bx  <= r2_bx;
            r3_by  <= r2_by;
            r3_cx  <= r2_cx;
            r3_cy  <= r2_cy;
            r3_x1  <= r2_x1;
            r3_y1  <= r2_y1;
        end
    end

    // ---------------- stage 4: split products, |det|, collinear test ----------------
    logic signed [LLO:0]   n4_lblo, n4_lclo;
    logic signed [LHI:0]   n4_lbhi, n4_lchi;
    logic [DETW-1:0]       n4_ad;
    logic                  n4_col;
    logic signed [PPW-1:0] r4_cylo, r4_cyhi, r4_bylo, r4_byhi;
    logic signed [PPW-1:0] r4_bxlo, r4_bxhi, r4_cxlo, r4_cxhi;
    logic [DETW-1:0]       r4_ad;
    logic                  r4_dneg, r4_col;
    logic signed [W-1:0]   r4_x1, r4_y1;

    always_comb begin
        n4_lblo = $signed({1'b0, r3_lb[LLO-1:0]});
        n4_lbhi = $signed({1'b0, r3_lb[LW-1:LLO]});
        n4_lclo = $signed({1'b0, r3_lc[LLO-1:0]});
        n4_lchi = $signed({1'b0, r3_lc[LW-1:LLO]});
        n4_ad   = r3_det[DETW-1] ? $unsigned(-r3_det) : $unsigned(r3_det);
        n4_col  = (n4_ad == '0) || (CMPW'(n4_ad) < CMPW'(r_thr));
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_cylo <= r3_cy * n4_lblo;
            r4_cyhi <= r3_cy * n4_lbhi;
            r4_bylo <= r3_by * n4_lclo;
            r4_byhi <= r3_by * n4_lchi;
            r4_bxlo <= r3_bx * n4_lclo;
            r4_bxhi <= r3_bx * n4_lchi;
            r4_cxlo <= r3_cx * n4_lblo;
            r4_cxhi <= r3_cx * n4_lbhi;
            r4_ad   <= n4_ad;
            r4_dneg <= r3_det[DETW-1];
            r4_col  <= n4_col;
            r4_x1   <= r3_x1;
            r4_y1   <= r3_y1;
        end
    end

    // ---------------- stage 5: join partial products ----------------
    logic signed [TW-1:0] r5_t1, r5_t2, r5_t3, r5_t4;
    logic [DETW-1:0]      r5_ad;
    logic                 r5_dneg, r5_col;
    logic signed [W-1:0]  r5_x1, r5_y1;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r5_t1   <= (TW'(r4_cyhi) <<< LLO) + TW'(r4_cylo);
            r5_t2   <= (TW'(r4_byhi) <<< LLO) + TW'(r4_bylo);
            r5_t3   <= (TW'(r4_bxhi) <<< LLO) + TW'(r4_bxlo);
            r5_t4   <= (TW'(r4_cxhi) <<< LLO) + TW'(r4_cxlo);
            r5_ad   <= r4_ad;
            r5_dneg <= r4_dneg;
            r5_col  <= r4_col;
            r5_x1   <= r4_x1;
            r5_y1   <= r4_y1;
        end
    end

    // ---------------- stage 6: numerators ----------------
    logic signed [NXW-1:0] r6_nx, r6_ny;
    logic [DETW-1:0]       r6_ad;
    logic                  r6_dneg, r6_col;
    logic signed [W-1:0]   r6_x1, r6_y1;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r6_nx   <= NXW'(r5_t1) - NXW'(r5_t2);
            r6_ny   <= NXW'(r5_t3) - NXW'(r5_t4);
            r6_ad   <= r5_ad;
            r6_dneg <= r5_dneg;
            r6_col  <= r5_col;
            r6_x1   <= r5_x1;
            r6_y1   <= r5_y1;
        end
    end

    // ---------------- stage 7: magnitudes and quotient signs ----------------
    logic [NXW-1:0]      r7_anx, r7_any;
    logic                r7_negx, r7_negy, r7_col;
    logic [DETW-1:0]     r7_ad;
    logic signed [W-1:0] r7_x1, r7_y1;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r7_anx  <= r6_nx[NXW-1] ? $unsigned(-r6_nx) : $unsigned(r6_nx);
            r7_any  <= r6_ny[NXW-1] ? $unsigned(-r6_ny) : $unsigned(r6_ny);
            r7_negx <= r6_nx[NXW-1] ^ r6_dneg;
            r7_negy <= r6_ny[NXW-1] ^ r6_dneg;
            r7_ad   <= r6_ad;
            r7_col  <= r6_col;
            r7_x1   <= r6_x1;
            r7_y1   <= r6_y1;
        end
    end

    // ---------------- stage 8: rounded dividend, divisor 2|det| ----------------
    logic [CW-1:0]       r8_numx, r8_numy, r8_den;
    logic                r8_negx, r8_negy, r8_col;
    logic signed [W-1:0] r8_x1, r8_y1;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r8_numx <= CW'(r7_anx) + CW'(r7_ad);
            r8_numy <= CW'(r7_any) + CW'(r7_ad);
            r8_den  <= CW'(r7_ad) << 1;
            r8_negx <= r7_negx;
            r8_negy <= r7_negy;
            r8_col  <= r7_col;
            r8_x1   <= r7_x1;
            r8_y1   <= r7_y1;
        end
    end

    // ---------------- divider: overflow check then one quotient bit per stage ----------------
    logic [CW-1:0]       r_dv_remx [QB+1];
    logic [CW-1:0]       r_dv_remy [QB+1];
    logic [CW-1:0]       r_dv_den  [QB+1];
    logic [QB-1:0]       r_dv_qx   [QB+1];
    logic [QB-1:0]       r_dv_qy   [QB+1];
    logic                r_dv_ovfx [QB+1];
    logic                r_dv_ovfy [QB+1];
    logic                r_dv_negx [QB+1];
    logic                r_dv_negy [QB+1];
    logic                r_dv_col  [QB+1];
    logic signed [W-1:0] r_dv_x1   [QB+1];
    logic signed [W-1:0] r_dv_y1   [QB+1];

    // quotient at or above 2^QB saturates the centre
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dv_remx[0] <= r8_numx;
            r_dv_remy[0] <= r8_numy;
            r_dv_den[0]  <= r8_den;
            r_dv_qx[0]   <= '0;
            r_dv_qy[0]   <= '0;
            r_dv_ovfx[0] <= r8_numx >= (r8_den << QB);
            r_dv_ovfy[0] <= r8_numy >= (r8_den << QB);
            r_dv_negx[0] <= r8_negx;
            r_dv_negy[0] <= r8_negy;
            r_dv_col[0]  <= r8_col;
            r_dv_x1[0]   <= r8_x1;
            r_dv_y1[0]   <= r8_y1;
        end
    end

    for (genvar j = 0; j < QB; j++) begin : g_div
        localparam int K = QB - 1 - j;
        logic [CW-1:0] n_sub;
        logic          n_tx, n_ty;

        // restoring step for quotient bit K
        always_comb begin
            n_sub = r_dv_den[j] << K;
            n_tx  = r_dv_remx[j] >= n_sub;
            n_ty  = r_dv_remy[j] >= n_sub;
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dv_remx[j+1] <= n_tx ? r_dv_remx[j] - n_sub : r_dv_remx[j];
                r_dv_remy[j+1] <= n_ty ? r_dv_remy[j] - n_sub : r_dv_remy[j];
                r_dv_qx[j+1]   <= r_dv_qx[j] | (n_tx ? (QB'(1) << K) : '0);
                r_dv_qy[j+1]   <= r_dv_qy[j] | (n_ty ? (QB'(1) << K) : '0);
                r_dv_den[j+1]  <= r_dv_den[j];
                r_dv_ovfx[j+1] <= r_dv_ovfx[j];
                r_dv_ovfy[j+1] <= r_dv_ovfy[j];
                r_dv_negx[j+1] <= r_dv_negx[j];
                r_dv_negy[j+1] <= r_dv_negy[j];
                r_dv_col[j+1]  <= r_dv_col[j];
                r_dv_x1[j+1]   <= r_dv_x1[j];
                r_dv_y1[j+1]   <= r_dv_y1[j];
            end
        end
    end

    // ---------------- centre stage: add offset, clamp ----------------
    logic signed [W+2:0] n_c_sx, n_c_sy;
    logic signed [W-1:0] n_c_cx, n_c_cy;
    logic                n_c_satx, n_c_saty;
    logic signed [W-1:0] r_c_cx, r_c_cy;
    logic                r_c_sat, r_c_rsat, r_c_col;
    logic [W-2:0]        r_c_qx, r_c_qy;

    always_comb begin
        n_c_sx = $signed({{3{r_dv_x1[QB][W-1]}}, r_dv_x1[QB]})
               + (r_dv_negx[QB] ? -$signed({2'b00, r_dv_qx[QB]})
                                :  $signed({2'b00, r_dv_qx[QB]}));
        n_c_sy = $signed({{3{r_dv_y1[QB][W-1]}}, r_dv_y1[QB]})
               + (r_dv_negy[QB] ? -$signed({2'b00, r_dv_qy[QB]})
                                :  $signed({2'b00, r_dv_qy[QB]}));
        n_c_satx = 1'b1;
        n_c_saty = 1'b1;
        if (r_dv_ovfx[QB]) begin
            n_c_cx = r_dv_negx[QB] ? CMIN : CMAX;
        end else if (n_c_sx > CMAX_E) begin
            n_c_cx = CMAX;
        end else if (n_c_sx < CMIN_E) begin
            n_c_cx = CMIN;
        end else begin
            n_c_cx   = n_c_sx[W-1:0];
            n_c_satx = 1'b0;
        end
        if (r_dv_ovfy[QB]) begin
            n_c_cy = r_dv_negy[QB] ? CMIN : CMAX;
        end else if (n_c_sy > CMAX_E) begin
            n_c_cy = CMAX;
        end else if (n_c_sy < CMIN_E) begin
            n_c_cy = CMIN;
        end else begin
            n_c_cy   = n_c_sy[W-1:0];
            n_c_saty = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c_cx   <= n_c_cx;
            r_c_cy   <= n_c_cy;
            r_c_sat  <= n_c_satx || n_c_saty;
            // offset beyond the radius range
            r_c_rsat <= r_dv_ovfx[QB] || r_dv_ovfy[QB]
                     || (r_dv_qx[QB][QB-1:W-1] != '0) || (r_dv_qy[QB][QB-1:W-1] != '0);
            r_c_qx   <= r_dv_qx[QB][W-2:0];
            r_c_qy   <= r_dv_qy[QB][W-2:0];
            r_c_col  <= r_dv_col[QB];
        end
    end

    // ---------------- squares of the offsets ----------------
    logic [2*W-3:0]      r_q_sx, r_q_sy;
    logic signed [W-1:0] r_q_cx, r_q_cy;
    logic                r_q_sat, r_q_rsat, r_q_col;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_q_sx   <= r_c_qx * r_c_qx;
            r_q_sy   <= r_c_qy * r_c_qy;
            r_q_cx   <= r_c_cx;
            r_q_cy   <= r_c_cy;
            r_q_sat  <= r_c_sat;
            r_q_rsat <= r_c_rsat;
            r_q_col  <= r_c_col;
        end
    end

    // ---------------- square root: one root bit per stage ----------------
    logic [XW-1:0]       r_sr_rem  [RB+1];
    logic [RB-1:0]       r_sr_root [RB+1];
    logic signed [W-1:0] r_sr_cx   [RB+1];
    logic signed [W-1:0] r_sr_cy   [RB+1];
    logic                r_sr_sat  [RB+1];
    logic                r_sr_rsat [RB+1];
    logic                r_sr_col  [RB+1];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sr_rem[0]  <= XW'(r_q_sx) + XW'(r_q_sy);
            r_sr_root[0] <= '0;
            r_sr_cx[0]   <= r_q_cx;
            r_sr_cy[0]   <= r_q_cy;
            r_sr_sat[0]  <= r_q_sat;
            r_sr_rsat[0] <= r_q_rsat;
            r_sr_col[0]  <= r_q_col;
        end
    end

    for (genvar j = 0; j < RB; j++) begin : g_sqrt
        localparam int B = RB - 1 - j;
        logic [XW-1:0] n_try;
        logic          n_take;

        // remainder holds s - root^2
        always_comb begin
            n_try  = (XW'(r_sr_root[j]) << (B + 1)) + (XW'(1) << (2 * B));
            n_take = r_sr_rem[j] >= n_try;
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_sr_rem[j+1]  <= n_take ? r_sr_rem[j] - n_try : r_sr_rem[j];
                r_sr_root[j+1] <= r_sr_root[j] | (n_take ? (RB'(1) << B) : '0);
                r_sr_cx[j+1]   <= r_sr_cx[j];
                r_sr_cy[j+1]   <= r_sr_cy[j];
                r_sr_sat[j+1]  <= r_sr_sat[j];
                r_sr_rsat[j+1] <= r_sr_rsat[j];
                r_sr_col[j+1]  <= r_sr_col[j];
            end
        end
    end

    // ---------------- output stage: round, clamp, status ----------------
    logic [W:0]          n_o_rad;
    logic                n_o_rsat;
    logic signed [W-1:0] r_o_cx, r_o_cy;
    logic [W-2:0]        r_o_rad;
    t_status             r_o_st;

    always_comb begin
        // round up when remainder exceeds root
        n_o_rad  = (W+1)'(r_sr_root[RB])
                 + (W+1)'(r_sr_rem[RB] > XW'(r_sr_root[RB]));
        n_o_rsat = r_sr_rsat[RB] || (n_o_rad > (W+1)'(RMAX));
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (r_sr_col[RB]) begin
                r_o_cx  <= '0;
                r_o_cy  <= '0;
                r_o_rad <= '0;
                r_o_st  <= ST_COLLINEAR;
            end else begin
                r_o_cx  <= r_sr_cx[RB];
                r_o_cy  <= r_sr_cy[RB];
                r_o_rad <= n_o_rsat ? RMAX : n_o_rad[W-2:0];
                r_o_st  <= (n_o_rsat || r_sr_sat[RB]) ? ST_SATURATED : ST_CIRCLE;
            end
        end
    end

    assign o_center_x = r_o_cx;
    assign o_center_y = r_o_cy;
    assign o_radius   = r_o_rad;
    assign o_status   = r_o_st;

    // ---------------- assertions ----------------
    `CF3P_ASSERT_RST(a_rst_empty, !i_rst_n |=> !o_out_valid, "output valid right after reset")
    `CF3P_ASSERT(a_stall_back, o_out_valid && i_out_stall |-> o_in_stall, "input taken while output held")
    `CF3P_ASSERT(a_col_zero, o_out_valid && o_status == ST_COLLINEAR |-> o_radius == '0 && o_center_x == '0 && o_center_y == '0, "collinear result not zero")
    `CF3P_ASSERT(a_sat_limit, o_out_valid && o_status == ST_SATURATED |-> o_radius == RMAX || o_center_x == CMAX || o_center_x == CMIN || o_center_y == CMAX || o_center_y == CMIN, "saturated result at no limit")

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for circle_from_three_points: directed and random point triples,
// several threshold settings. Depends on cf3p_pkg and the block RTL.
module tb;
    import cf3p_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CW-2:0] RMAX = '1;
    localparam int LATENCY = 2 * CW + 14;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic [CW-2:0]        rad;
        t_status              st;
    } t_circle;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [THR_WIDTH-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic signed [CW-1:0] i_first_x = '0, i_first_y = '0, i_second_x = '0;
    logic signed [CW-1:0] i_second_y = '0, i_third_x = '0, i_third_y = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic signed [CW-1:0] o_center_x, o_center_y;
    logic [CW-2:0] o_radius;
    logic [1:0] o_status;

    circle_from_three_points uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [THR_WIDTH-1:0] thr_model;
    t_circle expected_circles[$];
    int errors = 0;
    longint cycles = 0;
    int stall_mode = 0;

    // centre offset round(num / 2det), ties away from zero
    function automatic logic signed [255:0] round_div(logic signed [255:0] num,
                                                      logic signed [255:0] det);
        logic [255:0] an, ad, q;
        an = num < 0 ? -num : num;
        ad = det < 0 ? -det : det;
        q = (an + ad) / (ad << 1);
        return ((num < 0) != (det < 0)) ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic [63:0] isqrt_round(logic [63:0] s);
        logic [63:0] r, b;
        r = 0;
        for (int i = 31; i >= 0; i--) begin
            b = r | (64'd1 << i);
            if (b * b <= s) r = b;
        end
        // nearest: compare s against r*r + r
        return (s - r * r > r) ? r + 1 : r;
    endfunction

    function automatic t_circle predict_circle(logic signed [CW-1:0] p[6]);
        logic signed [255:0] x1, y1, bx, by, cx, cy, det, ad, lb, lc, nx, ny, ox, oy, c;
        logic [255:0] mx, my;
        t_circle r;
        logic sat;
        x1 = p[0]; y1 = p[1];
        bx = p[2] - x1; by = p[3] - y1;
        cx = p[4] - x1; cy = p[5] - y1;
        det = bx * cy - by * cx;
        ad = det < 0 ? -det : det;
        r = '0;
        if (ad == 0 || ad < $signed({216'd0, thr_model})) begin
            r.st = ST_COLLINEAR;
            return r;
        end
        sat = 1'b0;
        lb = bx * bx + by * by;
        lc = cx * cx + cy * cy;
        nx = cy * lb - by * lc;
        ny = bx * lc - cx * lb;
        ox = round_div(nx, det);
        oy = round_div(ny, det);
        c = x1 + ox;
        if (c > CMAX) begin r.cx = CMAX; sat = 1; end
        else if (c < CMIN) begin r.cx = CMIN; sat = 1; end
        else r.cx = c[CW-1:0];
        c = y1 + oy;
        if (c > CMAX) begin r.cy = CMAX; sat = 1; end
        else if (c < CMIN) begin r.cy = CMIN; sat = 1; end
        else r.cy = c[CW-1:0];
        mx = ox < 0 ? -ox : ox;
        my = oy < 0 ? -oy : oy;
        if (mx > RMAX || my > RMAX) begin
            r.rad = RMAX; sat = 1;
        end else begin
            mx = isqrt_round(mx * mx + my * my);
            if (mx > RMAX) begin r.rad = RMAX; sat = 1; end
            else r.rad = mx[CW-2:0];
        end
        r.st = sat ? ST_SATURATED : ST_CIRCLE;
        return r;
    endfunction

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver stall pattern
    always @(posedge i_clk) begin
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(3) == 0);
            2: i_out_stall <= ($urandom_range(1) == 0);
            default: i_out_stall <= ($urandom_range(7) != 0);
        endcase
        if ($urandom_range(200) == 0) stall_mode <= $urandom_range(3);
    end

    // result checker
    always @(posedge i_clk) begin
        t_circle e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_circles.size() == 0) begin
                $display("%0t unexpected result beat", $realtime);
                errors++;
            end else begin
                e = expected_circles.pop_front();
                if (o_center_x !== e.cx) begin
                    $display("%0t center_x exp %0d got %0d", $realtime, e.cx, o_center_x);
                    errors++;
                end
                if (o_center_y !== e.cy) begin
                    $display("%0t center_y exp %0d got %0d", $realtime, e.cy, o_center_y);
                    errors++;
                end
                if (o_radius !== e.rad) begin
                    $display("%0t radius exp %0d got %0d", $realtime, e.rad, o_radius);
                    errors++;
                end
                if (o_status !== e.st) begin
                    $display("%0t status exp %0d got %0d", $realtime, e.st, o_status);
                    errors++;
                end
            end
        end
    end

    int burst_left = 0;

    // send one triple, with random bursts and gaps; valid drops only for a gap
    task automatic send_triple(logic signed [CW-1:0] p[6]);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(20, 1);
            gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_first_x <= p[0]; i_first_y <= p[1];
        i_second_x <= p[2]; i_second_y <= p[3];
        i_third_x <= p[4]; i_third_y <= p[5];
        expected_circles.insert(expected_circles.size(), predict_circle(p));
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // called right after the last accepting edge
    task automatic drain();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (expected_circles.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [THR_WIDTH-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        thr_model = v;
    endtask

    function automatic logic signed [CW-1:0] rand_coord(int span);
        case (span)
            0: return $signed(CW'($urandom));
            1: return $signed(CW'($urandom_range(2000))) - 1000;
            default: return $signed(CW'($urandom_range(32'h7FFFF))) - 32'sh40000;
        endcase
    endfunction

    task automatic test_directed();
        logic signed [CW-1:0] p[6];
        logic signed [CW-1:0] ext[4] = '{CMIN, CMAX, 0, -1};
        p = '{0, 0, 65536, 0, 0, 65536}; send_triple(p);      // right triangle
        p = '{0, 0, 1, 1, 2, 2}; send_triple(p);              // collinear, zero det
        p = '{5, 5, 5, 5, 5, 5}; send_triple(p);              // coincident points
        p = '{0, 0, 1, 0, 0, 1}; send_triple(p);              // det of one
        p = '{0, 0, 1, 0, 2, 1}; send_triple(p);              // tie rounding
        p = '{CMIN, CMIN, CMAX, CMIN, CMIN, CMAX}; send_triple(p);
        p = '{CMAX, CMAX, CMIN, CMAX, CMAX, CMIN}; send_triple(p);
        p = '{CMIN, CMAX, CMAX, CMAX, 0, CMIN}; send_triple(p);
        p = '{0, 0, CMAX, 1, CMIN, 0}; send_triple(p);        // saturated centre
        p = '{-1, -1, 1, -1, -1, 1}; send_triple(p);           // centre at the origin
        for (int i = 0; i < 10; i++) begin
            foreach (p[k]) p[k] = ext[$urandom_range(3)];
            send_triple(p);
        end
    endtask

    task automatic test_random(int n);
        logic signed [CW-1:0] p[6];
        int span;
        for (int i = 0; i < n; i++) begin
            span = $urandom_range(2);
            foreach (p[k]) p[k] = rand_coord(span);
            if ($urandom_range(9) == 0) begin
                // points on a line through the first one
                p[4] = p[0] + 2 * (p[2] - p[0]);
                p[5] = p[1] + 2 * (p[3] - p[1]);
            end
            send_triple(p);
        end
    endtask

    initial begin
        thr_model = THR_RESET;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(300);
        drain();
        write_threshold('0);
        test_directed();
        test_random(300);
        drain();
        write_threshold('1);
        test_random(150);
        drain();
        write_threshold(40'd1 << 20);
        test_random(250);
        drain();
        write_threshold(40'd2);
        test_random(250);
        drain();
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+design
design/cf3p_pkg.sv
design/circle_from_three_points.sv
tb/tb.sv
